// ===== rtl/lmts_pkg.sv =====
// Shared types, register map and timing constants for the LCD mode timing block.
package lmts_pkg;

  // Item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Register offsets from the LCD register base
  localparam logic [3:0] REG_LCDC = 4'h0;
  localparam logic [3:0] REG_STAT = 4'h1;
  localparam logic [3:0] REG_SCY  = 4'h2;
  localparam logic [3:0] REG_SCX  = 4'h3;
  localparam logic [3:0] REG_LY   = 4'h4;
  localparam logic [3:0] REG_LYC  = 4'h5;
  localparam logic [3:0] REG_BGP  = 4'h7;
  localparam logic [3:0] REG_WY   = 4'hA;
  localparam logic [3:0] REG_WX   = 4'hB;

  // Display modes held in STAT bits 1..0
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Dot budgets per mode
  localparam logic [15:0] DOTS_OAM    = 16'd80;
  localparam logic [15:0] DOTS_XFER   = 16'd172;
  localparam logic [15:0] DOTS_HBLANK = 16'd204;
  localparam logic [15:0] DOTS_LINE   = 16'd456;
  localparam logic [15:0] DOTS_MAX    = 16'hFFFF;

  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  localparam logic [7:0] STAT_WR_MASK = 8'hF8;
  localparam logic [7:0] STAT_RO_MASK = 8'h07;
  localparam logic [7:0] UNMAPPED_RD  = 8'hFF;

  // STAT and LCDC bit positions
  localparam int unsigned STAT_LYC_FLAG = 2;
  localparam int unsigned STAT_EN_HBL   = 3;
  localparam int unsigned STAT_EN_VBL   = 4;
  localparam int unsigned STAT_EN_OAM   = 5;
  localparam int unsigned STAT_EN_LYC   = 6;
  localparam int unsigned LCDC_ENABLE   = 7;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
  } lmts_item_t;

  typedef struct packed {
    logic [7:0]  ctrl;
    logic [7:0]  stat;
    logic [7:0]  scy;
    logic [7:0]  scx;
    logic [7:0]  ly;
    logic [7:0]  lyc;
    logic [7:0]  bgp;
    logic [7:0]  wy;
    logic [7:0]  wx;
    logic [15:0] dots;
  } lmts_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic [7:0] line_now;
    logic [1:0] mode_now;
  } lmts_result_t;

  // True when any enabled STAT source is active for the given status byte.
  function automatic logic stat_sources(input logic [7:0] stat);
    logic [1:0] m;
    m = stat[1:0];
    return (stat[STAT_EN_HBL] && (m == MODE_HBLANK)) ||
           (stat[STAT_EN_VBL] && (m == MODE_VBLANK)) ||
           (stat[STAT_EN_OAM] && (m == MODE_OAM))    ||
           (stat[STAT_EN_LYC] && stat[STAT_LYC_FLAG]);
  endfunction

endpackage

// ===== rtl/lcd_mode_timing_and_stat.sv =====
// Top level of the LCD mode timing and STAT interrupt block.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item: a tick
//   of tick_cycles_i machine cycles (four dots each), a register write of
//   write_data_i at reg_offset_i, or a register read at reg_offset_i.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result beat
//   per item: read_data_o, the vblank_irq_o and stat_irq_o pulses, and the
//   scanline and mode after the item.
//   Path: an accepted item is captured in the input register, evaluated
//   against the LCD state, and its result is registered when the result
//   register is empty or draining, which raises out_valid_o.
//   Throughput: one item per cycle while no result is stalled; the state
//   update is a single add, compare and subtract on the 16-bit dot counter
//   between the input register and the result register.
//   Stall: while out_stall_i holds a result, the next item waits in the
//   input register and in_stall_o rises only when that register is full;
//   no beat is lost or repeated.
//   Reset: rst_ni clears all LCD registers, the dot counter and both valid
//   flags; the block accepts a beat in the first cycle after reset.
module lcd_mode_timing_and_stat (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [3:0] reg_offset_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] tick_cycles_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o,
  output logic [7:0] line_now_o,
  output logic [1:0] mode_now_o
);

  lmts_pkg::lmts_item_t   in_item;
  lmts_pkg::lmts_item_t   item;
  logic                   item_valid;
  logic                   advance;
  lmts_pkg::lmts_state_t  state_q;
  lmts_pkg::lmts_state_t  state_d;
  lmts_pkg::lmts_result_t res_d;
  lmts_pkg::lmts_result_t res_q;
  logic                   out_valid_q;

  assign in_item.command     = command_i;
  assign in_item.reg_offset  = reg_offset_i;
  assign in_item.write_data  = write_data_i;
  assign in_item.tick_cycles = tick_cycles_i;

  // Advance the held item when the result register is empty or draining.
  assign advance = item_valid && (!out_valid_q || !out_stall_i);

  lmts_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .take_i       (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lmts_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // LCD state: commit only when the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = res_q.read_data;
  assign vblank_irq_o = res_q.vblank_irq;
  assign stat_irq_o   = res_q.stat_irq;
  assign line_now_o   = res_q.line_now;
  assign mode_now_o   = res_q.mode_now;

`ifndef SYNTHESIS
  // The input side backs up only behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A V-blank pulse comes only with entry to line 144 in V-blank.
  a_vblank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vblank_irq_o) |->
      (line_now_o == lmts_pkg::FIRST_VBLANK_LINE && mode_now_o == lmts_pkg::MODE_VBLANK))
    else $error("vblank pulse outside line 144 entry");

  // V-blank mode only on V-blank lines.
  a_vblank_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_now_o == lmts_pkg::MODE_VBLANK) |->
      (line_now_o >= lmts_pkg::FIRST_VBLANK_LINE))
    else $error("vblank mode on a visible line");

  // The line counter never passes the last line of the frame.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_now_o <= lmts_pkg::LAST_LINE))
    else $error("line counter past last line");
`endif

endmodule

// ===== rtl/lmts_in_reg.sv =====
// Input holding register: captures one beat and holds it until the core takes it.
module lmts_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmts_pkg::lmts_item_t item_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output lmts_pkg::lmts_item_t item_o
);

  logic                 valid_q;
  logic                 valid_d;
  lmts_pkg::lmts_item_t item_q;

  // Hold while a beat sits here and the core cannot take it.
  assign in_stall_o = valid_q && !take_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/lmts_step.sv =====
// Next-state and result logic for one item: register access or dot tick.
module lmts_step (
  input  lmts_pkg::lmts_state_t  state_i,
  input  lmts_pkg::lmts_item_t   item_i,
  output lmts_pkg::lmts_state_t  state_o,
  output lmts_pkg::lmts_result_t result_o
);

  always_comb begin
    lmts_pkg::lmts_state_t s;
    logic [16:0] sum;
    logic [7:0]  rd;
    logic        vb;
    logic        sirq;

    s    = state_i;
    rd   = 8'd0;
    vb   = 1'b0;
    sirq = 1'b0;
    sum  = {1'b0, state_i.dots} + {7'd0, item_i.tick_cycles, 2'b00};

    unique case (item_i.command)
      lmts_pkg::CMD_TICK: begin
        if (!s.ctrl[lmts_pkg::LCDC_ENABLE]) begin
          // LCD off: park at line 0, H-blank, no pulses.
          s.dots     = 16'd0;
          s.ly       = 8'd0;
          s.stat[1:0] = lmts_pkg::MODE_HBLANK;
        end else begin
          s.dots = sum[16] ? lmts_pkg::DOTS_MAX : sum[15:0];
          unique case (s.stat[1:0])
            lmts_pkg::MODE_OAM: begin
              if (s.dots >= lmts_pkg::DOTS_OAM) begin
                s.dots      = s.dots - lmts_pkg::DOTS_OAM;
                s.stat[1:0] = lmts_pkg::MODE_XFER;
              end
            end
            lmts_pkg::MODE_XFER: begin
              if (s.dots >= lmts_pkg::DOTS_XFER) begin
                s.dots      = s.dots - lmts_pkg::DOTS_XFER;
                s.stat[1:0] = lmts_pkg::MODE_HBLANK;
                if (lmts_pkg::stat_sources(s.stat)) sirq = 1'b1;
              end
            end
            lmts_pkg::MODE_HBLANK: begin
              if (s.dots >= lmts_pkg::DOTS_HBLANK) begin
                s.dots = s.dots - lmts_pkg::DOTS_HBLANK;
                s.ly   = s.ly + 8'd1;
                if (s.ly == s.lyc) begin
                  s.stat[lmts_pkg::STAT_LYC_FLAG] = 1'b1;
                  if (lmts_pkg::stat_sources(s.stat)) sirq = 1'b1;
                end else begin
                  s.stat[lmts_pkg::STAT_LYC_FLAG] = 1'b0;
                end
                if (s.ly == lmts_pkg::FIRST_VBLANK_LINE) begin
                  s.stat[1:0] = lmts_pkg::MODE_VBLANK;
                  vb          = 1'b1;
                end else begin
                  s.stat[1:0] = lmts_pkg::MODE_OAM;
                end
                if (lmts_pkg::stat_sources(s.stat)) sirq = 1'b1;
              end
            end
            default: begin
              if (s.dots >= lmts_pkg::DOTS_LINE) begin
                s.dots = s.dots - lmts_pkg::DOTS_LINE;
                s.ly   = s.ly + 8'd1;
                // Wrap past the last V-blank line into a new frame.
                if (s.ly > lmts_pkg::LAST_LINE) begin
                  s.ly        = 8'd0;
                  s.stat[1:0] = lmts_pkg::MODE_OAM;
                  if (lmts_pkg::stat_sources(s.stat)) sirq = 1'b1;
                end
                if (s.ly == s.lyc) begin
                  s.stat[lmts_pkg::STAT_LYC_FLAG] = 1'b1;
                  if (lmts_pkg::stat_sources(s.stat)) sirq = 1'b1;
                end else begin
                  s.stat[lmts_pkg::STAT_LYC_FLAG] = 1'b0;
                end
              end
            end
          endcase
        end
      end
      lmts_pkg::CMD_WRITE: begin
        unique case (item_i.reg_offset)
          lmts_pkg::REG_LCDC: s.ctrl = item_i.write_data;
          lmts_pkg::REG_STAT: s.stat = (s.stat & lmts_pkg::STAT_RO_MASK) |
                                       (item_i.write_data & lmts_pkg::STAT_WR_MASK);
          lmts_pkg::REG_SCY:  s.scy  = item_i.write_data;
          lmts_pkg::REG_SCX:  s.scx  = item_i.write_data;
          lmts_pkg::REG_LYC:  s.lyc  = item_i.write_data;
          lmts_pkg::REG_BGP:  s.bgp  = item_i.write_data;
          lmts_pkg::REG_WY:   s.wy   = item_i.write_data;
          lmts_pkg::REG_WX:   s.wx   = item_i.write_data;
          default: ;  // read-only LY and unmapped offsets: drop the write
        endcase
      end
      lmts_pkg::CMD_READ: begin
        unique case (item_i.reg_offset)
          lmts_pkg::REG_LCDC: rd = s.ctrl;
          lmts_pkg::REG_STAT: rd = s.stat;
          lmts_pkg::REG_SCY:  rd = s.scy;
          lmts_pkg::REG_SCX:  rd = s.scx;
          lmts_pkg::REG_LY:   rd = s.ly;
          lmts_pkg::REG_LYC:  rd = s.lyc;
          lmts_pkg::REG_BGP:  rd = s.bgp;
          lmts_pkg::REG_WY:   rd = s.wy;
          lmts_pkg::REG_WX:   rd = s.wx;
          default:            rd = lmts_pkg::UNMAPPED_RD;
        endcase
      end
      default: ;  // no operation
    endcase

    state_o             = s;
    result_o.read_data  = rd;
    result_o.vblank_irq = vb;
    result_o.stat_irq   = sirq;
    result_o.line_now   = s.ly;
    result_o.mode_now   = s.stat[1:0];
  end

endmodule

// ===== bench/lcd_mode_timing_and_stat_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the LCD mode timing and STAT interrupt block.
module lcd_mode_timing_and_stat_tb;
  import lmts_pkg::*;

  // Offsets with no register behind them: the DMA slot and a spare address.
  localparam logic [3:0] REG_DMA   = 4'h6;
  localparam logic [3:0] REG_SPARE = 4'hF;

  localparam int unsigned RANDOM_BEATS  = 1225; // stimulus length after the directed part
  localparam int unsigned CALM_TAIL     = 150;  // last beats run with no idling on either side
  localparam int unsigned LONG_HOLD     = 250;  // receiver hold-off that backs the block up
  localparam int unsigned QUIET_LIMIT   = 3000; // cycles with no accepted beat before giving up
  localparam int unsigned SETTLE_CYCLES = 8;    // extra cycles after the last result

  // One pending input beat; drain_first holds it back until every
  // predicted result has been seen on the output side.
  typedef struct packed {
    logic       drain_first;
    lmts_item_t beat;
  } bus_beat_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] cmd        = CMD_TICK;
  logic [3:0] reg_off    = REG_LCDC;
  logic [7:0] wr_data    = 8'h00;
  logic [7:0] tick_cyc   = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] rd_data;
  logic       vblank_irq;
  logic       stat_irq;
  logic [7:0] line_now;
  logic [1:0] mode_now;

  // Shadow copy of the LCD registers and the dot counter.
  logic [7:0]  sh_lcdc = '0;
  logic [7:0]  sh_stat = '0;
  logic [7:0]  sh_scy  = '0;
  logic [7:0]  sh_scx  = '0;
  logic [7:0]  sh_ly   = '0;
  logic [7:0]  sh_lyc  = '0;
  logic [7:0]  sh_bgp  = '0;
  logic [7:0]  sh_wy   = '0;
  logic [7:0]  sh_wx   = '0;
  logic [15:0] sh_dots = '0;

  bus_beat_t    bus_beats_q[$];   // input beats not yet handed to the block
  lmts_result_t lcd_results_q[$]; // predicted results, oldest first

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left     = 0;  // sender idle cycles still to go
  int unsigned run_left     = 0;  // sender beats that must go out back to back
  int unsigned hold_left    = 0;  // receiver stall cycles still to go
  logic        calm_phase   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcd_mode_timing_and_stat u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (cmd),
    .reg_offset_i  (reg_off),
    .write_data_i  (wr_data),
    .tick_cycles_i (tick_cyc),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (rd_data),
    .vblank_irq_o  (vblank_irq),
    .stat_irq_o    (stat_irq),
    .line_now_o    (line_now),
    .mode_now_o    (mode_now)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // High when any enabled STAT source is active in the shadow status byte.
  function automatic logic stat_source_up();
    logic [1:0] mode;
    mode = sh_stat[1:0];
    if (sh_stat[STAT_EN_HBL] && mode == MODE_HBLANK) return 1'b1;
    if (sh_stat[STAT_EN_VBL] && mode == MODE_VBLANK) return 1'b1;
    if (sh_stat[STAT_EN_OAM] && mode == MODE_OAM) return 1'b1;
    return sh_stat[STAT_EN_LYC] && sh_stat[STAT_LYC_FLAG];
  endfunction

  // Re-evaluate LY==LYC; a match requests STAT when any source is active.
  function automatic logic refresh_lyc_flag();
    sh_stat[STAT_LYC_FLAG] = (sh_ly == sh_lyc);
    return (sh_ly == sh_lyc) && stat_source_up();
  endfunction

  // Apply one beat to the shadow state and work out the result it causes.
  task automatic advance_lcd(input lmts_item_t it, output lmts_result_t res);
    logic [16:0] dot_sum;
    logic [7:0]  rd;
    logic        vb;
    logic        st;
    rd = '0;
    vb = 1'b0;
    st = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (!sh_lcdc[LCDC_ENABLE]) begin
          // LCD off: park at line 0 in H-blank, keep the coincidence flag
          sh_dots      = '0;
          sh_ly        = '0;
          sh_stat[1:0] = MODE_HBLANK;
        end else begin
          // four dots per machine cycle, saturating before the mode test
          dot_sum = {1'b0, sh_dots} + {7'd0, it.tick_cycles, 2'b00};
          sh_dots = dot_sum[16] ? DOTS_MAX : dot_sum[15:0];
          case (sh_stat[1:0])
            MODE_OAM: begin
              if (sh_dots >= DOTS_OAM) begin
                sh_dots      = sh_dots - DOTS_OAM;
                sh_stat[1:0] = MODE_XFER;
              end
            end
            MODE_XFER: begin
              if (sh_dots >= DOTS_XFER) begin
                sh_dots      = sh_dots - DOTS_XFER;
                sh_stat[1:0] = MODE_HBLANK;
                if (stat_source_up()) st = 1'b1;
              end
            end
            MODE_HBLANK: begin
              if (sh_dots >= DOTS_HBLANK) begin
                sh_dots = sh_dots - DOTS_HBLANK;
                sh_ly   = sh_ly + 8'd1;
                if (refresh_lyc_flag()) st = 1'b1;
                if (sh_ly == FIRST_VBLANK_LINE) begin
                  sh_stat[1:0] = MODE_VBLANK;
                  vb           = 1'b1;
                end else begin
                  sh_stat[1:0] = MODE_OAM;
                end
                if (stat_source_up()) st = 1'b1;
              end
            end
            default: begin
              // V-blank lines run a whole line each; wrap to line 0 after the last
              if (sh_dots >= DOTS_LINE) begin
                sh_dots = sh_dots - DOTS_LINE;
                sh_ly   = sh_ly + 8'd1;
                if (sh_ly > LAST_LINE) begin
                  sh_ly        = '0;
                  sh_stat[1:0] = MODE_OAM;
                  if (stat_source_up()) st = 1'b1;
                end
                if (refresh_lyc_flag()) st = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_WRITE: begin
        case (it.reg_offset)
          REG_LCDC: sh_lcdc = it.write_data;
          REG_STAT: sh_stat = (sh_stat & STAT_RO_MASK) | (it.write_data & STAT_WR_MASK);
          REG_SCY:  sh_scy  = it.write_data;
          REG_SCX:  sh_scx  = it.write_data;
          REG_LYC:  sh_lyc  = it.write_data;
          REG_BGP:  sh_bgp  = it.write_data;
          REG_WY:   sh_wy   = it.write_data;
          REG_WX:   sh_wx   = it.write_data;
          default: ; // LY is read-only; DMA and unmapped offsets drop the write
        endcase
      end
      CMD_READ: begin
        case (it.reg_offset)
          REG_LCDC: rd = sh_lcdc;
          REG_STAT: rd = sh_stat;
          REG_SCY:  rd = sh_scy;
          REG_SCX:  rd = sh_scx;
          REG_LY:   rd = sh_ly;
          REG_LYC:  rd = sh_lyc;
          REG_BGP:  rd = sh_bgp;
          REG_WY:   rd = sh_wy;
          REG_WX:   rd = sh_wx;
          default:  rd = UNMAPPED_RD;
        endcase
      end
      default: ; // no operation
    endcase
    res.read_data  = rd;
    res.vblank_irq = vb;
    res.stat_irq   = st;
    res.line_now   = sh_ly;
    res.mode_now   = sh_stat[1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_beat(input logic [1:0] c, input logic [3:0] o,
                            input logic [7:0] d, input logic [7:0] n,
                            input logic drain = 1'b0);
    bus_beat_t b;
    b.drain_first      = drain;
    b.beat.command     = c;
    b.beat.reg_offset  = o;
    b.beat.write_data  = d;
    b.beat.tick_cycles = n;
    bus_beats_q.push_back(b);
  endtask

  // Short directed opening: register map, read-only and unmapped offsets, the no-op
  // command, LCD off, and one walk through the H-blank, OAM search and transfer changes.
  task automatic load_directed();
    queue_beat(CMD_READ,  REG_LCDC,  8'h00, 8'h00);
    queue_beat(CMD_READ,  REG_STAT,  8'h00, 8'h00);
    queue_beat(CMD_NOP,   REG_SPARE, 8'hFF, 8'hFF);
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'hFF);   // LCD still off
    queue_beat(CMD_WRITE, REG_SCY,   8'hFF, 8'h00);
    queue_beat(CMD_WRITE, REG_BGP,   8'hE4, 8'h00);
    queue_beat(CMD_WRITE, REG_WY,    8'h5A, 8'h00);
    queue_beat(CMD_WRITE, REG_WX,    8'hA5, 8'h00);
    queue_beat(CMD_WRITE, REG_LY,    8'h55, 8'h00);   // read-only, dropped
    queue_beat(CMD_WRITE, REG_DMA,   8'h77, 8'h00);   // DMA slot, dropped
    queue_beat(CMD_WRITE, REG_SPARE, 8'h33, 8'h00);   // unmapped, dropped
    queue_beat(CMD_READ,  REG_SCY,   8'h00, 8'h00);
    queue_beat(CMD_READ,  REG_LY,    8'h00, 8'h00);
    queue_beat(CMD_READ,  REG_DMA,   8'h00, 8'h00);
    queue_beat(CMD_READ,  REG_SPARE, 8'h00, 8'h00);
    queue_beat(CMD_WRITE, REG_STAT,  8'hFF, 8'h00);   // low three bits must hold
    queue_beat(CMD_READ,  REG_STAT,  8'h00, 8'h00);
    queue_beat(CMD_WRITE, REG_LYC,   8'h01, 8'h00);
    queue_beat(CMD_WRITE, REG_LCDC,  8'h91, 8'h00);
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'd51);   // H-blank done, line 1 matches LYC
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'd20);   // OAM search done
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'd43);   // transfer done
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'd0);
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'hFF);
    queue_beat(CMD_WRITE, REG_LCDC,  8'h00, 8'h00);
    queue_beat(CMD_TICK,  REG_LCDC,  8'h00, 8'd7);    // LCD off clears line and mode
    queue_beat(CMD_READ,  REG_LYC,   8'h00, 8'h00);
  endtask

  // Random part: mostly runs of ticks with the LCD on so frames advance,
  // with register traffic mixed in; some raw noise and some max-size sprints
  // that drive the dot counter into saturation.
  task automatic load_random();
    logic [3:0]  mapped [0:8];
    logic [1:0]  c;
    logic [3:0]  o;
    logic [7:0]  d;
    logic [7:0]  n;
    int unsigned made;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic        mid_drain;
    mapped    = '{REG_LCDC, REG_STAT, REG_SCY, REG_SCX, REG_LYC,
                  REG_BGP, REG_WY, REG_WX, REG_LY};
    made      = 0;
    mid_drain = 1'b1;
    queue_beat(CMD_WRITE, REG_LCDC, 8'h80 | 8'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)), 1'b1);
    while (made < RANDOM_BEATS) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          queue_beat(CMD_WRITE, REG_LCDC, 8'h80 | 8'($urandom_range(0, 127)),
                     8'($urandom_range(0, 255)));
          queue_beat(CMD_WRITE, REG_STAT, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
          queue_beat(CMD_WRITE, REG_LYC, 8'($urandom_range(0, 153)),
                     8'($urandom_range(0, 255)));
          made += 3;
        end
        len = $urandom_range(20, 80);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          o = 4'($urandom_range(0, 15));
          d = 8'($urandom_range(0, 255));
          if (r < 82) begin
            r = $urandom_range(0, 9);
            if (r < 4)      n = 8'($urandom_range(0, 25));
            else if (r < 8) n = 8'($urandom_range(20, 64));
            else if (r < 9) n = 8'($urandom_range(64, 255));
            else            n = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            queue_beat(CMD_TICK, o, d, n);
          end else if (r < 90) begin
            queue_beat(CMD_READ, mapped[4'($urandom_range(0, 8))], d,
                       8'($urandom_range(0, 255)));
          end else if (r < 96) begin
            if ($urandom_range(0, 1))
              queue_beat(CMD_WRITE, REG_STAT, d, 8'($urandom_range(0, 255)));
            else
              queue_beat(CMD_WRITE, REG_LYC, 8'($urandom_range(0, 153)),
                         8'($urandom_range(0, 255)));
          end else begin
            queue_beat(CMD_WRITE, mapped[4'($urandom_range(2, 7))], d,
                       8'($urandom_range(0, 255)));
          end
          made++;
        end
      end else if (r < 9) begin
        len = $urandom_range(5, 25);
        for (k = 0; k < len; k++) begin
          c = 2'($urandom_range(0, 3));
          o = 4'($urandom_range(0, 15));
          d = 8'($urandom_range(0, 255));
          n = 8'($urandom_range(0, 255));
          // keep most control writes with the LCD on so the timing runs
          if (c == CMD_WRITE && o == REG_LCDC && $urandom_range(0, 3) != 0) d[LCDC_ENABLE] = 1'b1;
          queue_beat(c, o, d, n);
          made++;
        end
      end else begin
        len = $urandom_range(30, 60);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            queue_beat(CMD_READ, $urandom_range(0, 1) ? REG_LY : REG_STAT,
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          else
            queue_beat(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       8'hFF);
          made++;
        end
      end
      // halfway through, let the sender wait for the block to drain once
      if (mid_drain && made >= RANDOM_BEATS / 2) begin
        queue_beat(CMD_READ, REG_STAT, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b1);
        mid_drain = 1'b0;
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predict each accepted beat, then hold, idle or advance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_beat_t    head;
    lmts_item_t   taken;
    lmts_result_t predicted;
    logic         ready;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken = {cmd, reg_off, wr_data, tick_cyc};
        advance_lcd(taken, predicted);
        lcd_results_q.push_back(predicted);
      end
      calm_phase <= (bus_beats_q.size() < CALM_TAIL);
      // a stalled beat holds; otherwise pick what goes out next
      if (!in_valid || !in_stall) begin
        head  = '0;
        if (bus_beats_q.size() != 0) head = bus_beats_q[0];
        ready = (bus_beats_q.size() != 0) && !(head.drain_first && lcd_results_q.size() != 0);
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!ready) begin
          in_valid <= 1'b0;
        end else if (!calm_phase && run_left == 0 && $urandom_range(0, 2) == 0) begin
          // idle burst, then a random back-to-back stretch
          gap_left <= $urandom_range(0, 14);
          run_left <= $urandom_range(0, 40);
          in_valid <= 1'b0;
        end else begin
          head = bus_beats_q.pop_front();
          {cmd, reg_off, wr_data, tick_cyc} <= head.beat;
          in_valid <= 1'b1;
          if (run_left != 0) run_left <= run_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
               $time, results_seen, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lmts_result_t want;
    logic         took;
    took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        took = 1'b1;
        results_seen++;
        if (lcd_results_q.size() == 0) begin
          $display("%0t: result %0d expected none actual read 0x%0h line %0d mode %0d",
                   $time, results_seen, rd_data, line_now, mode_now);
          mismatches++;
        end else begin
          want = lcd_results_q.pop_front();
          check_field("read_data",  32'(want.read_data),  32'(rd_data));
          check_field("vblank_irq", 32'(want.vblank_irq), 32'(vblank_irq));
          check_field("stat_irq",   32'(want.stat_irq),   32'(stat_irq));
          check_field("line_now",   32'(want.line_now),   32'(line_now));
          check_field("mode_now",   32'(want.mode_now),   32'(mode_now));
        end
      end
      if (took && (results_seen == 300 || results_seen == 800)) begin
        // long hold-off: the sender keeps offering, so the block backs up
        hold_left <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on either side for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results still due",
               $time, QUIET_LIMIT, lcd_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, reset once, run until drained
  // ---------------------------------------------------------------------------
  initial begin
    load_directed();
    load_random();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // wait for the last beat to be taken, then for every result
    do @(posedge clk); while (bus_beats_q.size() != 0 || in_valid);
    do @(posedge clk); while (lcd_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
